>>> rtl/lzss_stream_decompressor_defines.svh
// assertion helpers for the lzss decompressor
`ifndef LZSS_STREAM_DECOMPRESSOR_DEFINES_SVH
`define LZSS_STREAM_DECOMPRESSOR_DEFINES_SVH

`ifndef SYNTHESIS
// property holds in the same cycle
`define LZSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent in one cycle, consequent in the next
`define LZSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LZSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define LZSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/lzss_pkg.sv
package lzss_pkg;

    // history window geometry
    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);

    // match length is stored minus this bias
    localparam int LEN_BIAS = 3;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_len16;

endpackage

>>> rtl/lzss_stream_decompressor.sv
// lzss stream decompressor, 12-bit distance, 4-bit length
// flag byte and low code byte: no output
// literal: the byte is presented on the next cycle
// match code: a window read, then an emit for each copied byte, 3 to 18 bytes;
// each emit waits for room at the output, and stream end can cut the copy short
// reset clears all control state; the window contents stay undefined until written
`include "lzss_stream_decompressor_defines.svh"

module lzss_stream_decompressor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration: output_length
    input  logic               i_cfg_wr_en,
    input  lzss_pkg::t_len16   i_cfg_wr_data,
    // compressed input
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  lzss_pkg::t_byte    i_s_axis_tdata,   // [7:0] in_byte
    // decompressed output
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output lzss_pkg::t_byte    o_m_axis_tdata,   // [7:0] out_byte
    output logic               o_m_axis_tlast,   // run_last
    output logic               o_m_axis_tuser    // [0] stream_end
);
    import lzss_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // token phases
    localparam logic [1:0] PH_FLAG  = 2'd0;
    localparam logic [1:0] PH_TOKEN = 2'd1;
    localparam logic [1:0] PH_HIGH  = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [1:0]  r_phase, n_phase;
    t_byte       r_flag_bits, n_flag_bits;
    logic [2:0]  r_flag_idx, n_flag_idx;
    t_byte       r_code_lo, n_code_lo;
    t_len16      r_pos, n_pos;
    t_len16      r_out_len;
    logic [11:0] r_dist, n_dist;
    logic [17:0] r_src, n_src;
    logic [4:0]  r_len, n_len;
    t_byte       r_rd_data;
    logic        r_out_valid, n_out_valid;
    t_byte       r_out_data, n_out_data;
    logic        r_out_last, n_out_last;
    logic        r_out_end, n_out_end;

    t_byte       r_window [WINDOW_DEPTH];

    logic        out_room;
    logic        in_fire;
    t_len16      pos_inc;
    logic        ended;
    logic        emit_now;
    t_byte       emit_val;
    logic        emit_last;
    logic        tok_done;
    logic [15:0] code_word;

    // shared emit path: position step and end-of-stream compare
    assign out_room  = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && out_room;
    assign in_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign pos_inc   = 16'(r_pos + 16'd1);
    assign ended     = (pos_inc == 16'd0) || (pos_inc >= r_out_len);
    assign code_word = {i_s_axis_tdata, r_code_lo};

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_flag_bits = r_flag_bits;
        n_flag_idx  = r_flag_idx;
        n_code_lo   = r_code_lo;
        n_pos       = r_pos;
        n_dist      = r_dist;
        n_src       = r_src;
        n_len       = r_len;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_end   = r_out_end;
        emit_now    = 1'b0;
        emit_val    = r_rd_data;
        emit_last   = 1'b0;
        tok_done    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (r_phase)
                        PH_TOKEN: begin
                            if (r_flag_bits[r_flag_idx]) begin
                                emit_now  = 1'b1;
                                emit_val  = i_s_axis_tdata;
                                emit_last = 1'b1;
                                tok_done  = 1'b1;
                            end else begin
                                n_code_lo = i_s_axis_tdata;
                                n_phase   = PH_HIGH;
                            end
                        end
                        PH_HIGH: begin
                            n_dist  = code_word[15:4];
                            n_len   = 5'(code_word[3:0]) + 5'(LEN_BIAS);
                            n_src   = 18'({2'b00, r_pos}) - 18'({6'd0, code_word[15:4]});
                            n_state = ST_READ;
                        end
                        default: begin
                            n_flag_bits = i_s_axis_tdata;
                            n_flag_idx  = 3'd0;
                            n_phase     = PH_TOKEN;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_room) begin
                    emit_now  = 1'b1;
                    // zero for distance zero or a source before stream start
                    emit_val  = ((r_dist != 12'd0) && !r_src[17]) ? r_rd_data : 8'd0;
                    emit_last = ended || (r_len == 5'd1);
                    n_len     = 5'(r_len - 5'd1);
                    n_src     = 18'(r_src + 18'd1);
                    tok_done  = emit_last;
                    n_state   = emit_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // load the output register
        if (emit_now) begin
            n_out_valid = 1'b1;
            n_out_data  = emit_val;
            n_out_last  = emit_last;
            n_out_end   = ended;
            n_pos       = ended ? 16'd0 : pos_inc;
        end

        // step to the next flag bit, or back to a flag byte after the eighth token or on stream end
        if (tok_done) begin
            if (ended || (r_flag_idx == 3'd7)) begin
                n_phase = PH_FLAG;
            end else begin
                n_flag_idx = 3'(r_flag_idx + 3'd1);
                n_phase    = PH_TOKEN;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_FLAG;
            r_flag_bits <= 8'd0;
            r_flag_idx  <= 3'd0;
            r_code_lo   <= 8'd0;
            r_pos       <= 16'd0;
            r_out_len   <= 16'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_flag_bits <= n_flag_bits;
            r_flag_idx  <= n_flag_idx;
            r_code_lo   <= n_code_lo;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_out_len <= i_cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_dist     <= n_dist;
        r_src      <= n_src;
        r_len      <= n_len;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_out_end  <= n_out_end;
    end

    // history window: write each emitted byte, registered read of the match source
    always_ff @(posedge i_clk) begin
        if (emit_now) begin
            r_window[r_pos[WIN_AW-1:0]] <= emit_val;
        end
        if (r_state == ST_READ) begin
            r_rd_data <= r_window[r_src[WIN_AW-1:0]];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_end;

    // checks
    `LZSS_ASSERT(a_len_live, i_clk, i_rst_n, (r_state == ST_IDLE) || (r_len != 5'd0), "match length ran out while copying")
    `LZSS_ASSERT(a_end_is_last, i_clk, i_rst_n, !(r_out_valid && r_out_end) || r_out_last, "stream end without run last")
    `LZSS_ASSERT_NEXT(a_end_restart, i_clk, i_rst_n, emit_now && ended, (r_pos == 16'd0) && (r_phase == PH_FLAG), "stream end did not restart")
    `LZSS_ASSERT_NEXT(a_read_then_emit, i_clk, i_rst_n, r_state == ST_READ, r_state == ST_EMIT, "window read not followed by emit")

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import lzss_pkg::*;

    localparam int IDLE_MAX     = 13;
    localparam int SETTLE_TICKS = 48;    // margin for the longest match to drain from the block
    localparam int RANDOM_ITEMS = 230;   // includes the directed bytes
    localparam int REPORT_MAX   = 10;

    typedef enum logic [1:0] {
        PH_FLAG    = 2'd0,
        PH_TOKEN   = 2'd1,
        PH_CODE_HI = 2'd2
    } t_phase;

    typedef struct packed {
        t_byte data;
        logic  run_last;
        logic  stream_end;
    } t_out_beat;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_cfg_wr_en;
    t_len16 i_cfg_wr_data;
    logic   i_s_axis_tvalid;
    logic   o_s_axis_tready;
    t_byte  i_s_axis_tdata;
    logic   o_m_axis_tvalid;
    logic   i_m_axis_tready;
    t_byte  o_m_axis_tdata;
    logic   o_m_axis_tlast;
    logic   o_m_axis_tuser;

    // decoder shadow state, reset values
    t_byte       win_mem [WINDOW_DEPTH];
    logic [15:0] dec_pos      = '0;
    logic [15:0] dec_len      = 16'd1;
    t_byte       dec_flags    = '0;
    int          dec_flag_idx = 8;
    t_phase      dec_phase    = PH_FLAG;
    t_byte       dec_code_lo  = '0;

    t_out_beat expected_out [$];
    int        mismatch_count = 0;

    // stream builder state and idle controls
    int gen_pos     = 0;
    int gen_len     = 1;
    int items_sent  = 0;
    bit tx_gap_on   = 1'b1;
    bit rx_stall_on = 1'b1;
    int rx_hold     = 0;

    lzss_stream_decompressor uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // write one decoded byte to the window and queue it; returns stream end
    function automatic bit push_out_byte(input t_byte v, input bit last_of_step);
        bit ended;
        t_out_beat beat;
        win_mem[dec_pos % WINDOW_DEPTH] = v;
        dec_pos = dec_pos + 16'd1;
        ended = (dec_pos == 16'd0) || (dec_pos >= dec_len);
        beat.data       = v;
        beat.run_last   = last_of_step || ended;
        beat.stream_end = ended;
        expected_out.push_back(beat);
        return ended;
    endfunction

    // move to the next flag bit, or back to a flag byte at stream end
    function automatic void next_token(input bit ended);
        if (ended) begin
            dec_pos      = '0;
            dec_flag_idx = 8;
            dec_phase    = PH_FLAG;
        end else begin
            dec_flag_idx++;
            dec_phase = (dec_flag_idx >= 8) ? PH_FLAG : PH_TOKEN;
        end
    endfunction

    // expected output bytes for one compressed byte
    function automatic void decompress_byte(input t_byte b);
        logic [15:0] code;
        int unsigned distance;
        int unsigned run_len;
        int          src_pos;
        int          k;
        t_byte       v;
        bit          ended;
        ended = 1'b0;
        case (dec_phase)
            PH_TOKEN: begin
                if (dec_flags[dec_flag_idx]) begin
                    ended = push_out_byte(b, 1'b1);
                    next_token(ended);
                end else begin
                    dec_code_lo = b;
                    dec_phase   = PH_CODE_HI;
                end
            end
            PH_CODE_HI: begin
                code     = {b, dec_code_lo};
                distance = code[15:4];
                run_len  = code[3:0] + LEN_BIAS;
                src_pos  = int'(dec_pos) - int'(distance);
                for (k = 0; k < run_len && !ended; k++) begin
                    v = '0;
                    if (distance != 0 && src_pos >= 0)
                        v = win_mem[src_pos % WINDOW_DEPTH];
                    ended = push_out_byte(v, k == run_len - 1);
                    src_pos++;
                end
                next_token(ended);
            end
            default: begin
                dec_flags    = b;
                dec_flag_idx = 0;
                dec_phase    = PH_TOKEN;
            end
        endcase
    endfunction

    // predict on each input transfer, check each output transfer
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                decompress_byte(i_s_axis_tdata);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_out.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: unexpected output byte %02h last %0b end %0b",
                                 $realtime, o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
                end else begin
                    want = expected_out.pop_front();
                    if (o_m_axis_tdata !== want.data || o_m_axis_tlast !== want.run_last ||
                        o_m_axis_tuser !== want.stream_end) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("%0t: byte exp %02h got %02h, last exp %0b got %0b, end exp %0b got %0b",
                                     $realtime, want.data, o_m_axis_tdata, want.run_last,
                                     o_m_axis_tlast, want.stream_end, o_m_axis_tuser);
                    end
                end
            end
        end
    end

    // output side: random stalls, plus long hold-offs on request
    initial begin
        int n;
        i_m_axis_tready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            n = rx_stall_on ? $urandom_range(0, IDLE_MAX) : 0;
            n += rx_hold;
            rx_hold = 0;
            if (n > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // one input transfer, with a random gap ahead of it
    task automatic send_byte(input t_byte b);
        int gap;
        gap = tx_gap_on ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
    endtask

    // stop sending and let every expected byte come out
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_out.size() != 0);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic set_length(input int len);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= t_len16'(len);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        dec_len = t_len16'(len);
        gen_len = len;
        @(posedge i_clk);
    endtask

    // flag byte plus up to eight tokens; well formed matches only reach back
    // into bytes already produced in this stream
    task automatic send_groups(input int n_groups, input int match_pct, input bit well_formed);
        t_byte       pkt [$];
        t_byte       flag;
        logic [15:0] code;
        int          g, bit_i, p, run_len, k, distance, max_d;
        bit          ended, is_lit;
        for (g = 0; g < n_groups; g++) begin
            pkt.delete();
            flag  = t_byte'($urandom_range(0, 255));
            p     = gen_pos;
            ended = 1'b0;
            for (bit_i = 0; bit_i < 8 && !ended; bit_i++) begin
                is_lit = ($urandom_range(0, 99) >= match_pct) || (well_formed && p == 0);
                if (is_lit) begin
                    flag[bit_i] = 1'b1;
                    pkt.push_back(t_byte'($urandom_range(0, 255)));
                    p = (p + 1) & 16'hFFFF;
                    ended = (p == 0) || (p >= gen_len);
                end else begin
                    flag[bit_i] = 1'b0;
                    max_d    = (p > 4095) ? 4095 : p;
                    distance = well_formed ? $urandom_range(1, max_d) : $urandom_range(0, 4095);
                    code     = {distance[11:0], 4'($urandom_range(0, 15))};
                    run_len  = code[3:0] + LEN_BIAS;
                    pkt.push_back(code[7:0]);
                    pkt.push_back(code[15:8]);
                    for (k = 0; k < run_len && !ended; k++) begin
                        p = (p + 1) & 16'hFFFF;
                        ended = (p == 0) || (p >= gen_len);
                    end
                end
            end
            send_byte(flag);
            foreach (pkt[i])
                send_byte(pkt[i]);
            gen_pos = ended ? 0 : p;
        end
    endtask

    // random bytes, then length one until the decoder is back at a stream start
    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
            send_byte(t_byte'($urandom_range(0, 255)));
        set_length(1);
        while (!(dec_phase == PH_FLAG && dec_pos == 16'd0)) begin
            send_byte(t_byte'($urandom_range(0, 255)));
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        gen_pos = 0;
    endtask

    task automatic test_directed();
        // length one after reset: a literal ends the stream at once
        send_byte(8'hFF);
        send_byte(8'hA5);
        // zero distance, longest match, clipped to one byte
        send_byte(8'h00);
        send_byte(8'h0F);
        send_byte(8'h00);
        set_length(16'hFFFF);
        // literal, then matches: longest run, source before the stream start,
        // far copy, zero distance, overlapping copy, shortest run
        send_byte(8'h01);
        send_byte(8'h5A);
        send_byte(8'h1F); send_byte(8'h00);
        send_byte(8'hF0); send_byte(8'hFF);
        send_byte(8'h30); send_byte(8'h01);
        send_byte(8'h02); send_byte(8'h00);
        send_byte(8'h45); send_byte(8'h00);
        send_byte(8'h10); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'h01);
        // length dropped below the position: the next literal ends the stream
        set_length(10);
        send_byte(8'hFF);
        send_byte(8'h77);
        gen_pos = 0;
    endtask

    task automatic test_short_streams();
        for (int i = 0; i < 4; i++) begin
            set_length($urandom_range(1, 24));
            send_groups(2, 50, 1'b1);
        end
    endtask

    task automatic test_no_idle();
        tx_gap_on   = 1'b0;
        rx_stall_on = 1'b0;
        set_length(16'hFFFF);
        send_groups(3, 60, 1'b1);
        tx_gap_on   = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    task automatic test_backpressure();
        tx_gap_on = 1'b0;
        rx_hold   = 400;
        send_groups(3, 85, 1'b1);
        tx_gap_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        send_groups(1, 50, 1'b1);
        wait_idle();
        send_groups(1, 50, 1'b1);
    endtask

    task automatic test_length_cut();
        set_length(16'hFFFF);
        send_groups(2, 50, 1'b1);
        if (gen_pos > 0)
            set_length($urandom_range(1, gen_pos));
        send_groups(1, 50, 1'b1);
    endtask

    task automatic test_random_mix();
        int match_pct;
        while (items_sent < RANDOM_ITEMS) begin
            tx_gap_on   = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 5))
                0:       set_length(1);
                1:       set_length(16'hFFFF);
                2, 3:    set_length($urandom_range(1, 64));
                4:       set_length($urandom_range(1, 400));
                default: wait_idle();
            endcase
            case ($urandom_range(0, 2))
                0:       match_pct = 20;
                1:       match_pct = 50;
                default: match_pct = 85;
            endcase
            if ($urandom_range(0, 9) == 0)
                send_noise($urandom_range(4, 16));
            else
                send_groups($urandom_range(1, 4), match_pct, $urandom_range(0, 9) != 0);
        end
    endtask

    // reset, tests in turn, final drain
    initial begin
        int guard;
        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_wr_data   <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_short_streams();
        test_no_idle();
        test_backpressure();
        test_drain_pause();
        test_length_cut();
        send_noise(12);
        test_random_mix();

        i_s_axis_tvalid <= 1'b0;
        guard = 0;
        while (expected_out.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (expected_out.size() != 0)
            $display("%0d expected bytes never came out", expected_out.size());
        if (mismatch_count == 0 && expected_out.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/lzss_pkg.sv
rtl/lzss_stream_decompressor.sv
bench/tb_top.sv
